FILE: hw/rtl/cho_pkg.sv
`default_nettype none

package cho_pkg;

	// Number of vertices held in the per-vertex tables.
	localparam int VERTEX_COUNT = 65536;
	localparam int VIDX_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

	// Fixed field widths of the stream.
	localparam int RAW_W = 20;
	localparam int RANGE_W = RAW_W + 1;
	localparam int MEMBER_W = 16;
	localparam int CID_W = 16;
	localparam int HV_W = 16;

	typedef logic [VIDX_W-1:0] vidx_t;

	typedef enum logic [1:0] {
		ACT_EDGE  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_START = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_READY,
		ST_EXEC
	} state_t;

	// One entry of the vertex table.
	typedef struct packed {
		logic             fc_valid;
		logic [CID_W-1:0] fc_id;
		logic             outlier;
		logic             hub;
	} vtx_entry_t;

	// Write port of the vertex table; the first-community field and the
	// flags have separate enables so a start sweep can keep the flags.
	typedef struct packed {
		logic       we_fc;
		logic       we_flags;
		vidx_t      addr;
		vtx_entry_t data;
	} vtx_wr_t;

	// Write port of the visited table.
	typedef struct packed {
		logic  we;
		vidx_t addr;
		logic  data;
	} vis_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cluster_hub_outlier_classifier.sv
// A result is loaded into the output register from the execute state that follows its beat's
// accept, once that register is free. A new beat is accepted only after the previous one has
// executed, set by the read-then-write pass over the tables. A start beat is followed by a sweep
// over all VERTEX_COUNT entries that clears the visited and first-community tables; no beat is
// accepted during it. Reset is asynchronous and active low; after it a sweep over all entries
// clears all tables, including the outlier and hub flags, before the first beat is taken.
`default_nettype none

module cluster_hub_outlier_classifier (
	input  logic                         clk,
	input  logic                         arst_n,

	// Configuration: neighbor offset register.
	input  logic                         cfg_we,
	input  logic [cho_pkg::RAW_W-1:0]    cfg_wdata,

	// Input channel.
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   action,
	input  logic [cho_pkg::MEMBER_W-1:0] member_vertex,
	input  logic                         member_in_community,
	input  logic [cho_pkg::CID_W-1:0]    community_id,
	input  logic [cho_pkg::RAW_W-1:0]    neighbor_raw_id,
	input  logic                         neighbor_in_community,
	input  logic                         last_edge_of_member,

	// Output channel.
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hub_pair_valid,
	output logic [cho_pkg::HV_W-1:0]     hub_vertex,
	output logic [cho_pkg::CID_W-1:0]    hub_community,
	output logic                         is_outlier,
	output logic                         is_hub,
	output logic                         index_error
);
	import cho_pkg::*;

	// Control state.
	state_t state_q, state_d;
	logic   clr_all_q;
	vidx_t  clr_cnt_q;
	logic   clr_last;
	logic   in_fire;
	logic   exec_go;
	logic   out_valid_q;
	logic [RAW_W-1:0] offset_q;

	// Input decode, done in the accept cycle so the table reads can be issued at once.
	action_t in_act;
	vidx_t   in_nv;
	logic    in_nv_ok;
	vidx_t   in_member;
	logic    in_member_ok;

	// Beat held for the execute cycle.
	action_t          act_s1;
	vidx_t            member_s1;
	logic             member_ok_s1;
	logic             mem_in_s1;
	logic [CID_W-1:0] cid_s1;
	vidx_t            nv_s1;
	logic             nv_ok_s1;
	logic             nei_in_s1;
	logic             last_s1;

	// Table ports.
	vtx_entry_t vtx_rd;
	logic       vis_rd;
	vtx_wr_t    vtx_wr;
	vis_wr_t    vis_wr;

	// Execute-cycle decisions.
	logic edge_live;
	logic upd;
	logic first_touch;
	logic hub_new;
	logic is_read;

	// Output register payload.
	logic             pair_q;
	logic [HV_W-1:0]  hub_vertex_q;
	logic [CID_W-1:0] hub_comm_q;
	logic             outlier_q;
	logic             hub_q;
	logic             ierr_q;

	//------------------------------------------------------------------
	// Configuration register. The user must write it only while the block is idle; the block itself does not enforce this.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	//------------------------------------------------------------------
	// Input decode. The same offset correction serves edges and reads.
	//------------------------------------------------------------------
	assign in_act       = action_t'(action);
	assign in_member    = VIDX_W'(member_vertex);
	assign in_member_ok = RANGE_W'(member_vertex) < RANGE_W'(VERTEX_COUNT);

	cho_index_map u_map (
		.raw_id (neighbor_raw_id),
		.offset (offset_q),
		.idx    (in_nv),
		.ok     (in_nv_ok)
	);

	assign in_fire = in_valid && !in_stall;

	// The beat is captured as it is accepted; both tables are read at the same
	// edge, so their data is ready in the execute cycle that follows.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_s1       <= in_act;
			member_s1    <= in_member;
			member_ok_s1 <= in_member_ok;
			mem_in_s1    <= member_in_community;
			cid_s1       <= community_id;
			nv_s1        <= in_nv;
			nv_ok_s1     <= in_nv_ok;
			nei_in_s1    <= neighbor_in_community;
			last_s1      <= last_edge_of_member;
		end
	end

	//------------------------------------------------------------------
	// Tables. The vertex table holds first community, outlier and hub flag
	// per neighbor; the visited table holds one mark per member. Read data
	// is registered and only reloads on an accepted beat, so it holds while
	// the execute cycle waits on the output.
	//------------------------------------------------------------------
	cho_vertex_table u_vtx (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (in_nv),
		.rd_data (vtx_rd),
		.wr      (vtx_wr)
	);

	cho_visited_table u_vis (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (in_member),
		.rd_data (vis_rd),
		.wr      (vis_wr)
	);

	//------------------------------------------------------------------
	// Execute cycle: classify and form the write-back.
	// A beat is only accepted once the previous write-back has landed, so a
	// read never sees a stale entry and no forwarding path is needed.
	//------------------------------------------------------------------
	assign edge_live   = (act_s1 == ACT_EDGE) && member_ok_s1 && mem_in_s1 && !vis_rd;
	assign upd         = edge_live && nv_ok_s1 && !nei_in_s1;
	assign first_touch = upd && !vtx_rd.fc_valid;
	assign hub_new     = upd && vtx_rd.fc_valid && (vtx_rd.fc_id != cid_s1);
	assign is_read     = (act_s1 == ACT_READ) && nv_ok_s1;

	always_comb begin
		vtx_wr = '0;
		vis_wr = '0;
		if (state_q == ST_CLEAR) begin
			// Sweep: first community always cleared, flags only after reset.
			vtx_wr.we_fc    = 1'b1;
			vtx_wr.we_flags = clr_all_q;
			vtx_wr.addr     = clr_cnt_q;
			vis_wr.we       = 1'b1;
			vis_wr.addr     = clr_cnt_q;
		end else begin
			vtx_wr.we_fc         = exec_go && first_touch;
			vtx_wr.we_flags      = exec_go && (first_touch || hub_new);
			vtx_wr.addr          = nv_s1;
			vtx_wr.data.fc_valid = 1'b1;
			vtx_wr.data.fc_id    = cid_s1;
			// The outlier flag stays set when a vertex turns into a hub.
			vtx_wr.data.outlier  = vtx_rd.outlier || first_touch;
			vtx_wr.data.hub      = vtx_rd.hub || hub_new;
			// The member is marked visited after its last edge, even when the
			// neighbor index was out of range.
			vis_wr.we            = exec_go && edge_live && last_s1;
			vis_wr.addr          = member_s1;
			vis_wr.data          = 1'b1;
		end
	end

	//------------------------------------------------------------------
	// Sequencer: clearing sweep, waiting for a beat, and execute.
	//------------------------------------------------------------------
	assign clr_last = (clr_cnt_q == VIDX_W'(VERTEX_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_all_q <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
			end
			if (exec_go && (act_s1 == ACT_START)) begin
				clr_all_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		exec_go  = 1'b0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_READY;
				end
			end
			ST_READY: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// The result needs a free output register before anything commits.
				exec_go = !out_valid_q || !out_stall;
				if (exec_go) begin
					state_d = (act_s1 == ACT_START) ? ST_CLEAR : ST_READY;
				end
			end
			default: begin
				state_d = ST_READY;
			end
		endcase
	end

	//------------------------------------------------------------------
	// Output register. It decouples the two sides: a new beat may be
	// accepted while a finished result still waits to be taken.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			pair_q       <= hub_new;
			hub_vertex_q <= hub_new ? HV_W'(nv_s1) : '0;
			hub_comm_q   <= hub_new ? cid_s1 : '0;
			outlier_q    <= is_read && vtx_rd.outlier;
			hub_q        <= is_read && vtx_rd.hub;
			ierr_q       <= ((act_s1 == ACT_EDGE) || (act_s1 == ACT_READ)) && !nv_ok_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign hub_pair_valid = pair_q;
	assign hub_vertex     = hub_vertex_q;
	assign hub_community  = hub_comm_q;
	assign is_outlier     = outlier_q;
	assign is_hub         = hub_q;
	assign index_error    = ierr_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cho_index_map.sv
`default_nettype none

module cho_index_map (
	input  logic [cho_pkg::RAW_W-1:0] raw_id,
	input  logic [cho_pkg::RAW_W-1:0] offset,
	output cho_pkg::vidx_t            idx,
	output logic                      ok
);
	import cho_pkg::*;

	logic [RANGE_W-1:0] diff;

	// The top bit of the difference is the borrow of raw_id - offset.
	assign diff = {1'b0, raw_id} - {1'b0, offset};
	assign ok   = !diff[RAW_W] && (diff < RANGE_W'(VERTEX_COUNT));
	assign idx  = diff[VIDX_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/cho_vertex_table.sv
`default_nettype none

module cho_vertex_table (
	input  logic                clk,
	input  logic                rd_en,
	input  cho_pkg::vidx_t      rd_addr,
	output cho_pkg::vtx_entry_t rd_data,
	input  cho_pkg::vtx_wr_t    wr
);
	import cho_pkg::*;

	vtx_entry_t mem_q [VERTEX_COUNT];

	always_ff @(posedge clk) begin
		if (wr.we_fc) begin
			mem_q[wr.addr].fc_valid <= wr.data.fc_valid;
			mem_q[wr.addr].fc_id    <= wr.data.fc_id;
		end
		if (wr.we_flags) begin
			mem_q[wr.addr].outlier <= wr.data.outlier;
			mem_q[wr.addr].hub     <= wr.data.hub;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/cho_visited_table.sv
`default_nettype none

module cho_visited_table (
	input  logic             clk,
	input  logic             rd_en,
	input  cho_pkg::vidx_t   rd_addr,
	output logic             rd_data,
	input  cho_pkg::vis_wr_t wr
);
	import cho_pkg::*;

	logic mem_q [VERTEX_COUNT];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/cho_port_checker.sv
`default_nettype none

module cho_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic hub_pair_valid,
	input logic [cho_pkg::HV_W-1:0] hub_vertex,
	input logic [cho_pkg::CID_W-1:0] hub_community,
	input logic is_outlier,
	input logic is_hub,
	input logic index_error
);
	import cho_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// One beat is worked on at a time: the port is busy right after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("beat accepted while previous one in flight");

	// A hub pair comes only from a valid edge and carries no read flags.
	a_pair_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hub_pair_valid |-> !index_error && !is_outlier && !is_hub)
		else $error("hub pair mixed with error or read flags");

	// Without a pair the pair fields are zero.
	a_pair_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hub_pair_valid |-> (hub_vertex == '0) && (hub_community == '0))
		else $error("pair fields set without a pair");

	// A vertex only becomes a hub after it was first marked outlier.
	a_hub_outlier: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_hub |-> is_outlier && !index_error)
		else $error("hub flag without outlier flag");

endmodule

bind cluster_hub_outlier_classifier cho_port_checker u_port_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.hub_pair_valid (hub_pair_valid),
	.hub_vertex     (hub_vertex),
	.hub_community  (hub_community),
	.is_outlier     (is_outlier),
	.is_hub         (is_hub),
	.index_error    (index_error)
);

`default_nettype wire
